[rtl/core/pwaw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwaw_pkg
// Shared types, constants and register codes of the angle-wrapping PID block.
// ----------------------------------------------------------------------------
package pwaw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF = 48;

  // pi in Q32.32
  localparam logic [63:0] PI_Q32 = 64'd13493037705;

  typedef logic signed [63:0] term_t;
  typedef logic signed [65:0] wide_t;
  typedef logic signed [97:0] accp_t;
  typedef logic signed [34:0] errw_t;

  localparam term_t TERM_LIM = 64'sh2000_0000_0000_0000;

  localparam int DDIV_W   = 63;
  localparam int TS_W     = 31;
  localparam int KI_MAG_W = 32;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KP    = 3'd0;
  localparam cfg_idx_t CFG_KI    = 3'd1;
  localparam cfg_idx_t CFG_KD    = 3'd2;
  localparam cfg_idx_t CFG_TS    = 3'd3;
  localparam cfg_idx_t CFG_UP    = 3'd4;
  localparam cfg_idx_t CFG_LO    = 3'd5;
  localparam cfg_idx_t CFG_ANGLE = 3'd6;

  localparam logic [TS_W-1:0] TS_RST = 31'd655;
  localparam logic signed [31:0] UP_RST = 32'sd196608;
  localparam logic signed [31:0] LO_RST = -32'sd196608;

  typedef struct packed {
    logic signed [31:0] reference;
    logic signed [31:0] feedback;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } out_t;

  typedef enum logic [2:0] {
    MUL_KD,
    MUL_KP,
    MUL_TS,
    MUL_ILO,
    MUL_IHI
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     calc_err;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     start_bdiv;
    logic     start_ddiv;
    logic     take_p;
    logic     take_inc;
    logic     integ;
    logic     acc_lo;
    logic     acc_hi;
    logic     take_i;
    logic     sum;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

[rtl/core/pwaw_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwaw_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwaw_div #(
  parameter int DW = pwaw_pkg::DDIV_W,
  parameter int VW = pwaw_pkg::TS_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, dsr_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   shifted, trial;
  logic          fits;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = !trial[VW];

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CW'(DW);
    end else if (busy_o) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

endmodule

[rtl/core/pwaw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwaw_dp
// Datapath: config registers, shared multiplier, two dividers, integrator
// and output register.
// ----------------------------------------------------------------------------
module pwaw_dp #(
  parameter int FRAC_BITS = pwaw_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = pwaw_pkg::ACC_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwaw_pkg::cmd_t     cmd_i,
  output pwaw_pkg::sts_t     sts_o,
  input  pwaw_pkg::in_t      in_data_i,
  input  logic               cfg_valid_i,
  input  pwaw_pkg::cfg_idx_t cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pwaw_pkg::out_t     out_data_o
);

  localparam int BndW = 32 + FRAC_BITS;

  localparam pwaw_pkg::term_t PiQ = pwaw_pkg::term_t'(
      (pwaw_pkg::PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam pwaw_pkg::errw_t PiE    = pwaw_pkg::errw_t'(PiQ);
  localparam pwaw_pkg::errw_t NegPiE = -PiE;
  localparam pwaw_pkg::errw_t TwoPiE = pwaw_pkg::errw_t'(PiQ + PiQ);
  localparam pwaw_pkg::errw_t ErrMax = pwaw_pkg::errw_t'(32'sh7FFF_FFFF);
  localparam pwaw_pkg::errw_t ErrMin = pwaw_pkg::errw_t'(32'sh8000_0000);

  localparam pwaw_pkg::wide_t AccMax =
      (pwaw_pkg::wide_t'(1) <<< (ACC_WIDTH - 1)) - pwaw_pkg::wide_t'(1);
  localparam pwaw_pkg::wide_t AccMin = -AccMax - pwaw_pkg::wide_t'(1);

  localparam pwaw_pkg::accp_t TermLimA = pwaw_pkg::accp_t'(pwaw_pkg::TERM_LIM);
  localparam pwaw_pkg::accp_t NegLimA  = -TermLimA;

  // configuration
  logic signed [31:0]        kp_q, ki_q, kd_q, up_q, lo_q;
  logic [pwaw_pkg::TS_W-1:0] ts_q, ts_eff;
  logic                      angle_q;

  // item state
  logic signed [31:0]        ref_q, fb_q, e_q, e_d, prev_q;
  logic signed [ACC_WIDTH-1:0] integ_q, integ_d;
  pwaw_pkg::wide_t           prod_q, prod_sh, prod_abs;
  pwaw_pkg::term_t           p_q, inc_q, d_q, d_d, d_mag, i_q, i_d, sum_q, i64;
  pwaw_pkg::accp_t           acc_q, acc_sh;
  logic                      dneg_q, bneg_q;
  logic                      out_valid_q;
  pwaw_pkg::out_t            out_q, out_d;

  pwaw_pkg::errw_t           e_raw, e_wrap;
  logic signed [32:0]        mul_a, mul_b;

  logic signed [31:0]        lim_sel;
  logic [BndW-1:0]           bnd_raw, bnd_mag;
  logic [pwaw_pkg::KI_MAG_W-1:0] ki_mag;
  logic [BndW-1:0]           bq;
  logic [pwaw_pkg::DDIV_W-1:0] dq;
  logic                      ddiv_busy, bdiv_busy;

  pwaw_pkg::wide_t           bnd_w, bound, integ_w, isum, isat;
  logic                      e_pos, e_neg, block;

  assign ts_eff = (ts_q == '0) ? pwaw_pkg::TS_W'(1) : ts_q;
  assign i64    = pwaw_pkg::term_t'(integ_q);

  // error with optional wrap and saturation
  always_comb begin
    e_raw  = pwaw_pkg::errw_t'(ref_q) - pwaw_pkg::errw_t'(fb_q);
    e_wrap = e_raw;
    if (angle_q) begin
      if (e_raw > PiE) begin
        e_wrap = e_raw - TwoPiE;
      end else if (e_raw < NegPiE) begin
        e_wrap = e_raw + TwoPiE;
      end
    end
    if (e_wrap > ErrMax) begin
      e_d = 32'sh7FFF_FFFF;
    end else if (e_wrap < ErrMin) begin
      e_d = 32'sh8000_0000;
    end else begin
      e_d = e_wrap[31:0];
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      pwaw_pkg::MUL_KD: begin
        mul_a = 33'(kd_q);
        mul_b = 33'(e_q) - 33'(prev_q);
      end
      pwaw_pkg::MUL_KP: begin
        mul_a = 33'(kp_q);
        mul_b = 33'(e_q);
      end
      pwaw_pkg::MUL_TS: begin
        mul_a = 33'(e_q);
        mul_b = {2'b00, ts_eff};
      end
      pwaw_pkg::MUL_ILO: begin
        mul_a = 33'(ki_q);
        mul_b = {1'b0, i64[31:0]};
      end
      pwaw_pkg::MUL_IHI: begin
        mul_a = 33'(ki_q);
        mul_b = {i64[63], i64[63:32]};
      end
      default: begin
        mul_a = 33'(kp_q);
        mul_b = 33'(e_q);
      end
    endcase
  end

  assign prod_sh  = prod_q >>> FRAC_BITS;
  assign prod_abs = prod_q[65] ? -prod_q : prod_q;

  // anti-windup bound operands
  assign lim_sel = e_q[31] ? lo_q : up_q;
  assign bnd_raw = {lim_sel, {FRAC_BITS{1'b0}}};
  assign bnd_mag = lim_sel[31] ? (~bnd_raw + BndW'(1)) : bnd_raw;
  assign ki_mag  = ki_q[31] ? (~ki_q + 32'd1) : ki_q;

  pwaw_div #(
    .DW(pwaw_pkg::DDIV_W),
    .VW(pwaw_pkg::TS_W)
  ) u_ddiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_ddiv),
    .dividend_i(prod_abs[pwaw_pkg::DDIV_W-1:0]),
    .divisor_i (ts_eff),
    .busy_o    (ddiv_busy),
    .quotient_o(dq)
  );

  pwaw_div #(
    .DW(BndW),
    .VW(pwaw_pkg::KI_MAG_W)
  ) u_bdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_bdiv),
    .dividend_i(bnd_mag),
    .divisor_i (ki_mag),
    .busy_o    (bdiv_busy),
    .quotient_o(bq)
  );

  // derivative term and integrator update
  always_comb begin
    d_mag = pwaw_pkg::term_t'({1'b0, dq});
    if (d_mag > pwaw_pkg::TERM_LIM) begin
      d_mag = pwaw_pkg::TERM_LIM;
    end
    d_d = dneg_q ? -d_mag : d_mag;

    bnd_w   = pwaw_pkg::wide_t'({1'b0, bq});
    bound   = bneg_q ? -bnd_w : bnd_w;
    integ_w = pwaw_pkg::wide_t'(integ_q);
    e_pos   = !e_q[31] && (e_q != '0);
    e_neg   = e_q[31];
    block   = (ki_q != '0) &&
              ((e_pos && (integ_w > bound)) || (e_neg && (integ_w < bound)));

    isum = integ_w + pwaw_pkg::wide_t'(inc_q);
    if (isum > AccMax) begin
      isat = AccMax;
    end else if (isum < AccMin) begin
      isat = AccMin;
    end else begin
      isat = isum;
    end
    integ_d = block ? integ_q : isat[ACC_WIDTH-1:0];
  end

  // integral term
  always_comb begin
    acc_sh = acc_q >>> FRAC_BITS;
    if (acc_sh > TermLimA) begin
      i_d = pwaw_pkg::TERM_LIM;
    end else if (acc_sh < NegLimA) begin
      i_d = -pwaw_pkg::TERM_LIM;
    end else begin
      i_d = acc_sh[63:0];
    end
  end

  // output clamp
  always_comb begin
    if (sum_q > pwaw_pkg::term_t'(up_q)) begin
      out_d.drive   = up_q;
      out_d.clamped = 1'b1;
    end else if (sum_q < pwaw_pkg::term_t'(lo_q)) begin
      out_d.drive   = lo_q;
      out_d.clamped = 1'b1;
    end else begin
      out_d.drive   = sum_q[31:0];
      out_d.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      ts_q        <= pwaw_pkg::TS_RST;
      up_q        <= pwaw_pkg::UP_RST;
      lo_q        <= pwaw_pkg::LO_RST;
      angle_q     <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pwaw_pkg::CFG_KP:    kp_q    <= cfg_data_i;
          pwaw_pkg::CFG_KI:    ki_q    <= cfg_data_i;
          pwaw_pkg::CFG_KD:    kd_q    <= cfg_data_i;
          pwaw_pkg::CFG_TS:    ts_q    <= cfg_data_i[pwaw_pkg::TS_W-1:0];
          pwaw_pkg::CFG_UP:    up_q    <= cfg_data_i;
          pwaw_pkg::CFG_LO:    lo_q    <= cfg_data_i;
          pwaw_pkg::CFG_ANGLE: angle_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.integ) begin
        integ_q <= integ_d;
      end
      if (cmd_i.load_out) begin
        prev_q      <= e_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ref_q <= in_data_i.reference;
      fb_q  <= in_data_i.feedback;
    end
    if (cmd_i.calc_err) begin
      e_q <= e_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= pwaw_pkg::wide_t'(mul_a) * pwaw_pkg::wide_t'(mul_b);
    end
    if (cmd_i.start_bdiv) begin
      bneg_q <= lim_sel[31] ^ ki_q[31];
    end
    if (cmd_i.start_ddiv) begin
      dneg_q <= prod_q[65];
    end
    if (cmd_i.take_p) begin
      p_q <= prod_sh[63:0];
    end
    if (cmd_i.take_inc) begin
      inc_q <= prod_sh[63:0];
    end
    if (cmd_i.integ) begin
      d_q <= d_d;
    end
    if (cmd_i.acc_lo) begin
      acc_q <= pwaw_pkg::accp_t'(prod_q);
    end else if (cmd_i.acc_hi) begin
      acc_q <= acc_q + (pwaw_pkg::accp_t'(prod_q) <<< 32);
    end
    if (cmd_i.take_i) begin
      i_q <= i_d;
    end
    if (cmd_i.sum) begin
      sum_q <= p_q + i_q + d_q;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign sts_o.div_busy = ddiv_busy | bdiv_busy;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

[rtl/core/pwaw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwaw_ctrl
// Sequencer that steps the datapath through one controller update.
// ----------------------------------------------------------------------------
module pwaw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pwaw_pkg::sts_t sts_i,
  output pwaw_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ERR   = 13'b0000000000010,
    S_MKD   = 13'b0000000000100,
    S_MKP   = 13'b0000000001000,
    S_MTS   = 13'b0000000010000,
    S_WDIV  = 13'b0000000100000,
    S_INTEG = 13'b0000001000000,
    S_MILO  = 13'b0000010000000,
    S_MIHI  = 13'b0000100000000,
    S_ACCUM = 13'b0001000000000,
    S_TERM  = 13'b0010000000000,
    S_SUM   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = pwaw_pkg::MUL_KD;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_MKD;
      end
      S_MKD: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = pwaw_pkg::MUL_KD;
        cmd_o.start_bdiv = 1'b1;
        state_d          = S_MKP;
      end
      S_MKP: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = pwaw_pkg::MUL_KP;
        cmd_o.start_ddiv = 1'b1;
        state_d          = S_MTS;
      end
      S_MTS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pwaw_pkg::MUL_TS;
        cmd_o.take_p  = 1'b1;
        state_d       = S_WDIV;
      end
      S_WDIV: begin
        cmd_o.take_inc = 1'b1;
        if (!sts_i.div_busy) begin
          state_d = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd_o.integ = 1'b1;
        state_d     = S_MILO;
      end
      S_MILO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pwaw_pkg::MUL_ILO;
        state_d       = S_MIHI;
      end
      S_MIHI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pwaw_pkg::MUL_IHI;
        cmd_o.acc_lo  = 1'b1;
        state_d       = S_ACCUM;
      end
      S_ACCUM: begin
        cmd_o.acc_hi = 1'b1;
        state_d      = S_TERM;
      end
      S_TERM: begin
        cmd_o.take_i = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/pid_with_antiwindup_angle_wrap_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_antiwindup_angle_wrap_top
// PID controller with conditional-integration anti-windup and angle wrap.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item holds reference and feedback (signed Q16.16).
//   out_* : one item per input, the clamped drive and a clamped flag.
//   cfg_* : register writes (gains, sample period, limits, angle mode);
//           always ready, write only while no item is in flight.
// Timing: items are taken one at a time; the next item can be accepted on
//   the cycle after the result of the last one is loaded. The 63-step
//   derivative divider (one quotient bit per cycle) is the longest step;
//   the anti-windup bound divider runs beside it and one shared 33x33
//   multiplier serves all five products.
// Reset: clears the integrator, the previous error and the output valid flag,
//   and loads the register defaults.
// Stall: a finished result sits in the output register; the next item is
//   still accepted and computed, then holds until the register frees up.
// ----------------------------------------------------------------------------
module pid_with_antiwindup_angle_wrap_top #(
  parameter int FRAC_BITS = pwaw_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = pwaw_pkg::ACC_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pwaw_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pwaw_pkg::out_t     out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  pwaw_pkg::cfg_idx_t cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  pwaw_pkg::cmd_t cmd;
  pwaw_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  pwaw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pwaw_dp #(
    .FRAC_BITS(FRAC_BITS),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an item");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !sts.out_busy)
    else $error("output register overwritten while stalled");

  a_integ_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.integ |-> !sts.div_busy)
    else $error("integrator update before divides finished");

  a_ddiv_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_ddiv |=> sts.div_busy)
    else $error("derivative divide did not start");

endmodule

[test/pid_with_antiwindup_angle_wrap_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_antiwindup_angle_wrap_top_test
// Self-checking bench for the angle-wrapping PID block with anti-windup.
//
// A directed table comes first. It covers field extremes, term and integrator
// saturation, the angle wrap, a zero sample period, inverted limits and
// an ignored register index. Eight random phases follow, each with fresh
// register settings. They cycle through four modes: no idling, sender gaps,
// receiver stalls, and both. A bit-true controller model predicts every
// result the table does not list; all are checked in order against the queue.
// ----------------------------------------------------------------------------
module pid_with_antiwindup_angle_wrap_top_test;
  import pwaw_pkg::*;

  typedef logic signed [127:0] big_t;

  localparam int     FRAC        = 16;
  localparam longint ONE_Q       = 64'sd65536;
  localparam longint PI_FIX      = 64'sd205887;  // round(pi * 2^16)
  localparam longint WORD_MAX    = 64'sh7FFF_FFFF;
  localparam longint WORD_MIN    = -64'sh8000_0000;
  localparam longint ACC_MAX     = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_MIN     = -ACC_MAX - 1;
  localparam longint TERM_CAP    = 64'sh2000_0000_0000_0000;
  localparam cfg_idx_t CFG_NONE  = 3'd7;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 219;
  localparam int     TAIL_CYCLES = 200;
  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     PRINT_CAP   = 200;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_data;
    in_t         stim;
    out_t        want;
  } dir_row_t;

  localparam int DIR_ROWS = 44;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h0000_0000_0000_0000, {32'h0, 1'b0}},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, {32'h0, 1'b0}},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h8000_0000_7FFF_FFFF, {32'h0, 1'b0}},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h8000_0000_8000_0000, {32'h0, 1'b0}},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h7FFF_FFFF_7FFF_FFFF, {32'h0, 1'b0}},
    '{ROW_CFG,   CFG_KP,    32'h7FFF_FFFF,   64'h0,                   '0},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, {32'h0003_0000, 1'b1}},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h8000_0000_7FFF_FFFF, {32'hFFFD_0000, 1'b1}},
    '{ROW_CFG,   CFG_KP,    32'h8000_0000,   64'h0,                   '0},
    '{ROW_KNOWN, CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, {32'hFFFD_0000, 1'b1}},
    '{ROW_CFG,   CFG_TS,    32'h7FFF_FFFF,   64'h0,                   '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, '0},
    '{ROW_CFG,   CFG_UP,    32'h7FFF_FFFF,   64'h0,                   '0},
    '{ROW_CFG,   CFG_LO,    32'h8000_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_KI,    32'h8000_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_KD,    32'h7FFF_FFFF,   64'h0,                   '0},
    '{ROW_CFG,   CFG_TS,    32'h0000_0001,   64'h0,                   '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h8000_0000_7FFF_FFFF, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0000_0000_0000_0000, '0},
    '{ROW_CFG,   CFG_KP,    32'h0001_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_KI,    32'h0000_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_KD,    32'h0000_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_UP,    32'h0004_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_LO,    32'hFFFC_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_ANGLE, 32'h0000_0001,   64'h0,                   '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0003_2440_0000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0003_243F_0000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0000_0000_0003_2440, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0010_0000_0000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h7FFF_FFFF_8000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h8000_0000_7FFF_FFFF, '0},
    '{ROW_CFG,   CFG_ANGLE, 32'h0000_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_KD,    32'h0001_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_TS,    32'h0000_0000,   64'h0,                   '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0001_0000_0000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'hFFFF_0000_0000_0000, '0},
    '{ROW_CFG,   CFG_UP,    32'hFFFF_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_LO,    32'h0001_0000,   64'h0,                   '0},
    '{ROW_CFG,   CFG_NONE,  32'h1234_5678,   64'h0,                   '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0005_0000_0000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'h0000_0000_0000_0000, '0},
    '{ROW_ITEM,  CFG_NONE,  32'h0,           64'hFFFB_0000_0000_0000, '0}
  };

  int unsigned send_gap_pct   [4] = '{0, 56, 0, 20};
  int unsigned recv_stall_pct [4] = '{0, 0, 56, 20};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_t    cfg_index_i = CFG_KP;
  logic [31:0] cfg_data_i  = '0;

  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;

  out_t drive_q [$];

  // controller model state and registers
  longint kp_gain   = 0;
  longint ki_gain   = 0;
  longint kd_gain   = 0;
  longint period    = 655;
  longint drive_max = 196608;
  longint drive_min = -196608;
  bit     wrap_en   = 1'b0;
  longint integ_acc = 0;
  longint last_err  = 0;

  pid_with_antiwindup_angle_wrap_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < PRINT_CAP) begin
      $display("[%0t] %s mismatch: got %h, want %h", $time, field, got, want);
    end
    mismatch_cnt++;
  endtask

  // floor(a * b / 2^16), held to the term range
  function automatic longint scaled_product(longint a, longint b);
    big_t prod;
    prod = (big_t'(a) * big_t'(b)) >>> FRAC;
    if (prod > big_t'(TERM_CAP)) begin
      prod = big_t'(TERM_CAP);
    end else if (prod < -big_t'(TERM_CAP)) begin
      prod = -big_t'(TERM_CAP);
    end
    return longint'(prod);
  endfunction

  function automatic void cfg_apply(cfg_idx_t idx, logic [31:0] data);
    case (idx)
      CFG_KP:    kp_gain   = longint'($signed(data));
      CFG_KI:    ki_gain   = longint'($signed(data));
      CFG_KD:    kd_gain   = longint'($signed(data));
      CFG_TS:    period    = longint'(data[30:0]);
      CFG_UP:    drive_max = longint'($signed(data));
      CFG_LO:    drive_min = longint'($signed(data));
      CFG_ANGLE: wrap_en   = data[0];
      default: ;
    endcase
  endfunction

  function automatic out_t pid_predict(in_t stim);
    longint err, per, pterm, iterm, dterm, incr, up_bound, lo_bound, total;
    big_t   quot;
    bit     allow;
    out_t   res;
    per = (period == 0) ? 1 : period;
    err = longint'($signed(stim.reference)) - longint'($signed(stim.feedback));
    if (wrap_en) begin
      if (err > PI_FIX) begin
        err -= 2 * PI_FIX;
      end else if (err < -PI_FIX) begin
        err += 2 * PI_FIX;
      end
    end
    if (err > WORD_MAX) begin
      err = WORD_MAX;
    end else if (err < WORD_MIN) begin
      err = WORD_MIN;
    end
    pterm = scaled_product(kp_gain, err);
    quot = (big_t'(kd_gain) * big_t'(err - last_err)) / big_t'(per);
    if (quot > big_t'(TERM_CAP)) begin
      quot = big_t'(TERM_CAP);
    end else if (quot < -big_t'(TERM_CAP)) begin
      quot = -big_t'(TERM_CAP);
    end
    dterm = longint'(quot);
    allow = 1'b1;
    if (ki_gain != 0) begin
      up_bound = (drive_max * ONE_Q) / ki_gain;
      lo_bound = (drive_min * ONE_Q) / ki_gain;
      if ((err > 0 && integ_acc > up_bound) || (err < 0 && integ_acc < lo_bound)) begin
        allow = 1'b0;
      end
    end
    if (allow) begin
      incr = scaled_product(err, per);
      if (incr > 0 && integ_acc > ACC_MAX - incr) begin
        integ_acc = ACC_MAX;
      end else if (incr < 0 && integ_acc < ACC_MIN - incr) begin
        integ_acc = ACC_MIN;
      end else begin
        integ_acc += incr;
      end
    end
    iterm = scaled_product(ki_gain, integ_acc);
    total = pterm + iterm + dterm;
    res.clamped = 1'b1;
    if (total > drive_max) begin
      res.drive = 32'(drive_max);
    end else if (total < drive_min) begin
      res.drive = 32'(drive_min);
    end else begin
      res.drive   = 32'(total);
      res.clamped = 1'b0;
    end
    last_err = err;
    return res;
  endfunction

  function automatic logic [31:0] rand_fix(int unsigned span);
    logic [31:0] half;
    int unsigned roll;
    half = 32'd1 << span;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return $urandom();
    end
    if (roll < 14) begin
      case ($urandom_range(4))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0001;
        3:       return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    return 32'($urandom_range(2 * half, 0)) - half;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_apply(idx, data);
  endtask

  task automatic send_item(in_t stim, bit known, out_t want);
    out_t predicted;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= stim;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = pid_predict(stim);
    drive_q.push_back(known ? want : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_data_o.drive, '0);
      end else begin
        want = drive_q.pop_front();
        if (out_data_o.drive !== want.drive) begin
          report_mismatch("drive", out_data_o.drive, want.drive);
        end
        if (out_data_o.clamped !== want.clamped) begin
          report_mismatch("clamped", 32'(out_data_o.clamped), 32'(want.clamped));
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] target, bias, lim_a, lim_b, up_word, lo_word, ts_word;
    in_t         stim;
    int unsigned roll;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_data);
      end else begin
        send_item(dir_tab[r].stim, dir_tab[r].kind == ROW_KNOWN, dir_tab[r].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      gap_pct   = send_gap_pct[ph % 4];
      stall_pct = recv_stall_pct[ph % 4];

      write_reg(CFG_KP, rand_fix(19));
      write_reg(CFG_KI, ($urandom_range(5) == 0) ? 32'd0 : rand_fix(18));
      write_reg(CFG_KD, rand_fix(17));
      case ($urandom_range(9))
        0:       ts_word = 32'd0;
        1:       ts_word = 32'h7FFF_FFFF;
        default: ts_word = $urandom_range(32'd1 << 17, 1);
      endcase
      ts_word[31] = 1'($urandom_range(1));
      write_reg(CFG_TS, ts_word);
      lim_a   = rand_fix(20);
      lim_b   = rand_fix(20);
      up_word = ($signed(lim_a) >= $signed(lim_b)) ? lim_a : lim_b;
      lo_word = ($signed(lim_a) >= $signed(lim_b)) ? lim_b : lim_a;
      if ($urandom_range(7) == 0) begin
        write_reg(CFG_UP, lo_word);
        write_reg(CFG_LO, up_word);
      end else begin
        write_reg(CFG_UP, up_word);
        write_reg(CFG_LO, lo_word);
      end
      write_reg(CFG_ANGLE, $urandom());
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_NONE, $urandom());
      end

      target = rand_fix(18);
      bias   = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          bias = rand_fix(16);
        end
        if ($urandom_range(19) == 0) begin
          target = rand_fix(18);
        end
        roll = $urandom_range(99);
        if (roll < 70) begin
          stim.reference = target;
          stim.feedback  = target - bias + 32'($urandom_range(8192, 0)) - 32'd4096;
        end else if (roll < 90) begin
          stim.reference = rand_fix(18);
          stim.feedback  = rand_fix(18);
        end else begin
          stim.reference = $urandom();
          stim.feedback  = $urandom();
        end
        send_item(stim, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
